FILE: design/ssb_pkg.sv
package ssb_pkg;

    // sizing of the block
    localparam int MAX_SIDE       = 64;
    localparam int MAX_SCALE      = 8;
    localparam int COORD_BITS     = 12;
    localparam int IDX_BITS       = $clog2(MAX_SIDE);
    localparam int SIDE_BITS      = IDX_BITS + 1;
    localparam int SCALE_BITS     = 4;
    localparam int SCALE_CNT_BITS = $clog2(MAX_SCALE) > 0 ? $clog2(MAX_SCALE) : 1;
    localparam int OFF_BITS       = IDX_BITS + SCALE_BITS;
    localparam int BYTE_BITS      = 8;
    localparam int ORIENT_BITS    = 2;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // configuration port
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_FIRST  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_SECOND = 3'd1;
    localparam logic [2:0] REG_SPRITE_SIDE   = 3'd2;
    localparam logic [2:0] REG_SCALE_FACTOR  = 3'd3;
    localparam logic [2:0] REG_ORIENTATION   = 3'd4;

    // orientation bits
    localparam int ORIENT_MIRROR_FIRST  = 1;
    localparam int ORIENT_MIRROR_SECOND = 0;

    typedef struct packed {
        logic [COORD_BITS-1:0]  origin_first;
        logic [COORD_BITS-1:0]  origin_second;
        logic [SIDE_BITS-1:0]   sprite_side;
        logic [SCALE_BITS-1:0]  scale_factor;
        logic [ORIENT_BITS-1:0] orientation;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0]     base_first;
        logic [COORD_BITS-1:0]     base_second;
        logic [SCALE_CNT_BITS-1:0] scale_m1;
        logic [BYTE_BITS-1:0]      chan0;
        logic [BYTE_BITS-1:0]      chan1;
        logic [BYTE_BITS-1:0]      chan2;
    } t_job;

endpackage

FILE: design/ssb_front.sv
module ssb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssb_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ssb_pkg::BYTE_BITS-1:0] i_src_byte0,
    input  logic [ssb_pkg::BYTE_BITS-1:0] i_src_byte1,
    input  logic [ssb_pkg::BYTE_BITS-1:0] i_src_byte2,
    input  logic                        i_full,
    output logic                        o_push,
    output ssb_pkg::t_job               o_job
);
    import ssb_pkg::*;

    logic [IDX_BITS-1:0]   r_outer, n_outer;
    logic [IDX_BITS-1:0]   r_inner, n_inner;
    logic [SIDE_BITS-1:0]  w_side;
    logic [SCALE_BITS-1:0] w_scale;
    logic [IDX_BITS-1:0]   w_outer, w_inner;
    logic [SIDE_BITS-1:0]  w_inner_inc, w_outer_inc;
    logic [OFF_BITS-1:0]   w_off_first, w_off_second;
    logic                  w_accept;

    // clamp side and scale into their working ranges
    always_comb begin
        if (i_cfg.sprite_side == '0) begin
            w_side = SIDE_BITS'(1);
        end else if (i_cfg.sprite_side > SIDE_BITS'(MAX_SIDE)) begin
            w_side = SIDE_BITS'(MAX_SIDE);
        end else begin
            w_side = i_cfg.sprite_side;
        end
        if (i_cfg.scale_factor == '0) begin
            w_scale = SCALE_BITS'(1);
        end else if (i_cfg.scale_factor > SCALE_BITS'(MAX_SCALE)) begin
            w_scale = SCALE_BITS'(MAX_SCALE);
        end else begin
            w_scale = i_cfg.scale_factor;
        end
    end

    // counters left beyond a smaller side restart at zero
    assign w_outer = ({1'b0, r_outer} >= w_side) ? '0 : r_outer;
    assign w_inner = ({1'b0, r_inner} >= w_side) ? '0 : r_inner;

    // handshake: a full queue holds off the source
    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && ((i_src_byte0 | i_src_byte1 | i_src_byte2) != '0);

    // row-major source position advance
    assign w_inner_inc = {1'b0, w_inner} + SIDE_BITS'(1);
    assign w_outer_inc = {1'b0, w_outer} + SIDE_BITS'(1);
    always_comb begin
        n_outer = r_outer;
        n_inner = r_inner;
        if (w_accept) begin
            if (w_inner_inc >= w_side) begin
                n_inner = '0;
                n_outer = (w_outer_inc >= w_side) ? '0 : w_outer_inc[IDX_BITS-1:0];
            end else begin
                n_inner = w_inner_inc[IDX_BITS-1:0];
                n_outer = w_outer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= '0;
            r_inner <= '0;
        end else begin
            r_outer <= n_outer;
            r_inner <= n_inner;
        end
    end

    // block base on each axis, mirrored axes count down
    assign w_off_first  = OFF_BITS'(w_outer) * OFF_BITS'(w_scale);
    assign w_off_second = OFF_BITS'(w_inner) * OFF_BITS'(w_scale);

    always_comb begin
        o_job.base_first = i_cfg.orientation[ORIENT_MIRROR_FIRST]
            ? i_cfg.origin_first - COORD_BITS'(w_off_first)
            : i_cfg.origin_first + COORD_BITS'(w_off_first);
        o_job.base_second = i_cfg.orientation[ORIENT_MIRROR_SECOND]
            ? i_cfg.origin_second - COORD_BITS'(w_off_second)
            : i_cfg.origin_second + COORD_BITS'(w_off_second);
        o_job.scale_m1 = SCALE_CNT_BITS'(w_scale - SCALE_BITS'(1));
        // channels go out in reverse byte order
        o_job.chan0 = i_src_byte2;
        o_job.chan1 = i_src_byte1;
        o_job.chan2 = i_src_byte0;
    end

endmodule

FILE: design/ssb_queue.sv
module ssb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssb_pkg::t_job o_job
);
    import ssb_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr, n_wptr;
    logic [QPTR_BITS-1:0] r_rptr, n_rptr;
    logic [QCNT_BITS-1:0] r_count, n_count;
    logic                 w_do_push, w_do_pop;

    assign o_full    = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = w_do_push ? r_wptr + QPTR_BITS'(1) : r_wptr;
        n_rptr  = w_do_pop ? r_rptr + QPTR_BITS'(1) : r_rptr;
        n_count = r_count + QCNT_BITS'(w_do_push) - QCNT_BITS'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

FILE: design/ssb_back.sv
module ssb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  ssb_pkg::t_job                  i_q_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ssb_pkg::COORD_BITS-1:0] o_write_first,
    output logic [ssb_pkg::COORD_BITS-1:0] o_write_second,
    output logic [ssb_pkg::BYTE_BITS-1:0]  o_chan0,
    output logic [ssb_pkg::BYTE_BITS-1:0]  o_chan1,
    output logic [ssb_pkg::BYTE_BITS-1:0]  o_chan2,
    output logic                           o_last_write
);
    import ssb_pkg::*;

    logic                      r_busy, n_busy;
    t_job                      r_job, n_job;
    logic [SCALE_CNT_BITS-1:0] r_a, n_a;
    logic [SCALE_CNT_BITS-1:0] r_b, n_b;
    logic                      r_out_valid;
    logic [COORD_BITS-1:0]     r_first, r_second;
    logic [BYTE_BITS-1:0]      r_c0, r_c1, r_c2;
    logic                      r_last;
    logic                      w_load, w_emit, w_end;

    // output register frees when empty or when its beat is taken
    assign w_load = !r_out_valid || !i_stall;
    assign w_emit = r_busy && w_load;
    assign w_end  = (r_a == r_job.scale_m1) && (r_b == r_job.scale_m1);
    assign o_pop  = i_q_valid && (!r_busy || (w_emit && w_end));

    // sub-offset walk: first axis outer, second axis inner
    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_a    = r_a;
        n_b    = r_b;
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_q_job;
            n_a    = '0;
            n_b    = '0;
        end else if (w_emit && w_end) begin
            n_busy = 1'b0;
        end else if (w_emit) begin
            if (r_b == r_job.scale_m1) begin
                n_b = '0;
                n_a = r_a + SCALE_CNT_BITS'(1);
            end else begin
                n_b = r_b + SCALE_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // job and write payload
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_a   <= n_a;
        r_b   <= n_b;
        if (w_emit) begin
            r_first  <= r_job.base_first + COORD_BITS'(r_a);
            r_second <= r_job.base_second + COORD_BITS'(r_b);
            r_c0     <= r_job.chan0;
            r_c1     <= r_job.chan1;
            r_c2     <= r_job.chan2;
            r_last   <= w_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_write_first  = r_first;
    assign o_write_second = r_second;
    assign o_chan0        = r_c0;
    assign o_chan1        = r_c1;
    assign o_chan2        = r_c2;
    assign o_last_write   = r_last;

endmodule

FILE: design/scaled_sprite_blitter_unit.sv
// an opaque job passes the queue and the back's job register before the output register
// each opaque pixel gives scale*scale writes, one per cycle while the output is not stalled
// transparent pixels are taken at the input and produce no write
// a two-entry job queue lets the input run ahead while the back expands a block
// reset (synchronous, active low) clears the source counters, queue and output valid
// and loads origin 0, side 8, scale 1, orientation 0
module scaled_sprite_blitter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssb_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ssb_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [ssb_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    // source pixel channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ssb_pkg::BYTE_BITS-1:0]     i_src_byte0,
    input  logic [ssb_pkg::BYTE_BITS-1:0]     i_src_byte1,
    input  logic [ssb_pkg::BYTE_BITS-1:0]     i_src_byte2,
    // framebuffer write channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssb_pkg::COORD_BITS-1:0]    o_write_first,
    output logic [ssb_pkg::COORD_BITS-1:0]    o_write_second,
    output logic [ssb_pkg::BYTE_BITS-1:0]     o_chan0,
    output logic [ssb_pkg::BYTE_BITS-1:0]     o_chan1,
    output logic [ssb_pkg::BYTE_BITS-1:0]     o_chan2,
    output logic                              o_last_write
);
    import ssb_pkg::*;

    t_cfg        r_cfg;
    logic [2:0]  w_reg_idx;
    logic        w_wr;
    logic        w_push, w_full, w_pop, w_q_valid;
    t_job        w_front_job, w_q_job;

    // register file
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_BITS-1:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_first  <= '0;
            r_cfg.origin_second <= '0;
            r_cfg.sprite_side   <= SIDE_BITS'(8);
            r_cfg.scale_factor  <= SCALE_BITS'(1);
            r_cfg.orientation   <= '0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_ORIGIN_FIRST:  r_cfg.origin_first  <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_SECOND: r_cfg.origin_second <= pwdata[COORD_BITS-1:0];
                REG_SPRITE_SIDE:   r_cfg.sprite_side   <= pwdata[SIDE_BITS-1:0];
                REG_SCALE_FACTOR:  r_cfg.scale_factor  <= pwdata[SCALE_BITS-1:0];
                REG_ORIENTATION:   r_cfg.orientation   <= pwdata[ORIENT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_reg_idx)
            REG_ORIGIN_FIRST:  prdata = PDATA_BITS'(r_cfg.origin_first);
            REG_ORIGIN_SECOND: prdata = PDATA_BITS'(r_cfg.origin_second);
            REG_SPRITE_SIDE:   prdata = PDATA_BITS'(r_cfg.sprite_side);
            REG_SCALE_FACTOR:  prdata = PDATA_BITS'(r_cfg.scale_factor);
            REG_ORIENTATION:   prdata = PDATA_BITS'(r_cfg.orientation);
            default:           prdata = '0;
        endcase
    end

    // front: takes pixels, drops transparent ones, computes block bases
    ssb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_src_byte0 (i_src_byte0),
        .i_src_byte1 (i_src_byte1),
        .i_src_byte2 (i_src_byte2),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_front_job)
    );

    ssb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    // back: expands each job into its block of writes
    ssb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_job        (w_q_job),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_write_first  (o_write_first),
        .o_write_second (o_write_second),
        .o_chan0        (o_chan0),
        .o_chan1        (o_chan1),
        .o_chan2        (o_chan2),
        .o_last_write   (o_last_write)
    );

endmodule

FILE: design/ssb_checker.sv
module ssb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [ssb_pkg::COORD_BITS-1:0] o_write_first,
    input logic [ssb_pkg::COORD_BITS-1:0] o_write_second,
    input logic [ssb_pkg::BYTE_BITS-1:0]  o_chan0,
    input logic [ssb_pkg::BYTE_BITS-1:0]  o_chan1,
    input logic [ssb_pkg::BYTE_BITS-1:0]  o_chan2,
    input logic                           o_last_write
);

    // reset clears the output valid and the input stall
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall set right after reset");

    // a stalled write beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_first)
            && $stable(o_write_second) && $stable(o_last_write))
        else $error("stalled write beat changed");

    // a block continues without a gap until its last write
    a_block_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_write |=> o_out_valid)
        else $error("gap inside a pixel block");

    // all writes of one block carry the same pixel
    a_block_same_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_write
            |=> $stable(o_chan0) && $stable(o_chan1) && $stable(o_chan2))
        else $error("pixel value changed inside a block");

endmodule

bind scaled_sprite_blitter_unit ssb_checker u_ssb_checker (.*);

FILE: test/scaled_sprite_blitter_unit_test.sv
`timescale 1ns / 1ps

module scaled_sprite_blitter_unit_test;
    import ssb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 110;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic [BYTE_BITS-1:0] b0;
        logic [BYTE_BITS-1:0] b1;
        logic [BYTE_BITS-1:0] b2;
    } t_pixel;

    typedef struct packed {
        logic [COORD_BITS-1:0] coord_first;
        logic [COORD_BITS-1:0] coord_second;
        logic [BYTE_BITS-1:0]  chan0;
        logic [BYTE_BITS-1:0]  chan1;
        logic [BYTE_BITS-1:0]  chan2;
        logic                  is_last;
    } t_fb_write;

    // clock and block ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [PDATA_BITS-1:0] pwdata = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_BITS-1:0]  i_src_byte0 = '0;
    logic [BYTE_BITS-1:0]  i_src_byte1 = '0;
    logic [BYTE_BITS-1:0]  i_src_byte2 = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [COORD_BITS-1:0] o_write_first;
    logic [COORD_BITS-1:0] o_write_second;
    logic [BYTE_BITS-1:0]  o_chan0;
    logic [BYTE_BITS-1:0]  o_chan1;
    logic [BYTE_BITS-1:0]  o_chan2;
    logic                  o_last_write;

    // shadow copy of the registers and the source counters
    logic [COORD_BITS-1:0]  sh_origin_first = '0;
    logic [COORD_BITS-1:0]  sh_origin_second = '0;
    logic [SIDE_BITS-1:0]   sh_side = SIDE_BITS'(8);
    logic [SCALE_BITS-1:0]  sh_scale = SCALE_BITS'(1);
    logic [ORIENT_BITS-1:0] sh_orient = '0;
    int src_row = 0;
    int src_col = 0;

    t_pixel    pixels_to_send[$];
    t_fb_write writes_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit pixel_taken = 1'b0;
    int idle_cycles = 0;
    int n_fail = 0;
    int n_opaque = 0;
    int n_clear = 0;
    int n_writes = 0;
    int n_settings = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    scaled_sprite_blitter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_byte0    (i_src_byte0),
        .i_src_byte1    (i_src_byte1),
        .i_src_byte2    (i_src_byte2),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_first  (o_write_first),
        .o_write_second (o_write_second),
        .o_chan0        (o_chan0),
        .o_chan1        (o_chan1),
        .o_chan2        (o_chan2),
        .o_last_write   (o_last_write)
    );

    // expand one source pixel into its block of framebuffer writes
    task automatic expand_pixel(input t_pixel px);
        int side;
        int scale;
        int base_first;
        int base_second;
        t_fb_write w;
        side  = (sh_side == 0) ? 1 : ((sh_side > MAX_SIDE) ? MAX_SIDE : int'(sh_side));
        scale = (sh_scale == 0) ? 1 : ((sh_scale > MAX_SCALE) ? MAX_SCALE : int'(sh_scale));
        // counters left beyond a shrunken side restart at zero
        if (src_row >= side) src_row = 0;
        if (src_col >= side) src_col = 0;
        if (px != '0) begin
            base_first  = sh_orient[ORIENT_MIRROR_FIRST] ?
                          sh_origin_first - src_row * scale : sh_origin_first + src_row * scale;
            base_second = sh_orient[ORIENT_MIRROR_SECOND] ?
                          sh_origin_second - src_col * scale : sh_origin_second + src_col * scale;
            for (int a = 0; a < scale; a++) begin
                for (int b = 0; b < scale; b++) begin
                    w.coord_first  = COORD_BITS'(base_first + a);
                    w.coord_second = COORD_BITS'(base_second + b);
                    w.chan0        = px.b2;
                    w.chan1        = px.b1;
                    w.chan2        = px.b0;
                    w.is_last      = (a == scale - 1) && (b == scale - 1);
                    writes_due.push_back(w);
                end
            end
            n_opaque++;
        end else begin
            n_clear++;
        end
        // row-major advance, wrap at the end of the sprite
        src_col++;
        if (src_col >= side) begin
            src_col = 0;
            src_row++;
            if (src_row >= side) src_row = 0;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // sample both channels, check writes and predict accepted pixels
    always @(posedge i_clk) begin : monitor
        t_fb_write w;
        pixel_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (writes_due.size() == 0) begin
                    $error("unexpected framebuffer write at (%0d, %0d)",
                           o_write_first, o_write_second);
                    n_fail++;
                end else begin
                    w = writes_due.pop_front();
                    check_field("write_first", w.coord_first, o_write_first);
                    check_field("write_second", w.coord_second, o_write_second);
                    check_field("chan0", w.chan0, o_chan0);
                    check_field("chan1", w.chan1, o_chan1);
                    check_field("chan2", w.chan2, o_chan2);
                    check_field("last_write", w.is_last, o_last_write);
                    n_writes++;
                end
            end
            if (pixel_taken) expand_pixel('{i_src_byte0, i_src_byte1, i_src_byte2});
        end
    end

    // pixel source and write sink, both change on the falling edge
    always @(negedge i_clk) begin : driver
        t_pixel px;
        if (i_rst_n) begin
            if (!i_in_valid || pixel_taken) begin
                if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    px = pixels_to_send.pop_front();
                    i_in_valid  <= 1'b1;
                    i_src_byte0 <= px.b0;
                    i_src_byte1 <= px.b1;
                    i_src_byte2 <= px.b2;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // apb write: setup then access, shadow updated at the write edge
    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ORIGIN_FIRST:  sh_origin_first = value[COORD_BITS-1:0];
            REG_ORIGIN_SECOND: sh_origin_second = value[COORD_BITS-1:0];
            REG_SPRITE_SIDE:   sh_side = value[SIDE_BITS-1:0];
            REG_SCALE_FACTOR:  sh_scale = value[SCALE_BITS-1:0];
            REG_ORIENTATION:   sh_orient = value[ORIENT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int org_first, input int org_second, input int side,
                                 input int scale, input int orient);
        write_reg(REG_ORIGIN_FIRST, org_first);
        write_reg(REG_ORIGIN_SECOND, org_second);
        write_reg(REG_SPRITE_SIDE, side);
        write_reg(REG_SCALE_FACTOR, scale);
        write_reg(REG_ORIENTATION, orient);
        n_settings++;
    endtask

    // hold the source back until every pending write has come out
    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || i_in_valid || writes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        if ($urandom_range(99) < 20) return '0;
        px.b0 = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
        px.b1 = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
        px.b2 = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255));
        return px;
    endfunction

    // origins near both ends of the coordinate range are favored
    function automatic int random_origin();
        if ($urandom_range(3) != 0) return $urandom_range(4095);
        return $urandom_range(1) ? 4095 - $urandom_range(7) : $urandom_range(7);
    endfunction

    initial begin : stimulus
        int remaining;
        int sent;
        int n;
        int side;
        int scale;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 76;

        // reset settings: transparent pixels, byte extremes, walking bits
        pixels_to_send.push_back('{8'h00, 8'h00, 8'h00});
        pixels_to_send.push_back('{8'hFF, 8'hFF, 8'hFF});
        pixels_to_send.push_back('{8'h01, 8'h00, 8'h00});
        pixels_to_send.push_back('{8'h00, 8'h01, 8'h00});
        pixels_to_send.push_back('{8'h00, 8'h00, 8'h01});
        pixels_to_send.push_back('{8'h80, 8'h00, 8'h00});
        pixels_to_send.push_back('{8'h00, 8'h80, 8'h00});
        pixels_to_send.push_back('{8'h00, 8'h00, 8'h80});
        pixels_to_send.push_back('{8'h00, 8'h00, 8'h00});
        pixels_to_send.push_back('{8'hAA, 8'h55, 8'hAA});
        pixels_to_send.push_back('{8'h55, 8'hAA, 8'h55});
        wait_idle();

        // side 0 and scale 0 act as 1, both counters now beyond the side
        apply_setting(5, 4095, 0, 0, 2);
        pixels_to_send.push_back('{8'd12, 8'd34, 8'd56});
        pixels_to_send.push_back('{8'd200, 8'd1, 8'd99});
        wait_idle();

        // scale above max, both axes mirrored, wrap on both axes, sprite end
        apply_setting(3, 4090, 2, 15, 3);
        pixels_to_send.push_back('{8'd1, 8'd2, 8'd3});
        pixels_to_send.push_back('{8'd4, 8'd5, 8'd6});
        pixels_to_send.push_back('{8'd0, 8'd0, 8'd0});
        pixels_to_send.push_back('{8'd7, 8'd8, 8'd9});
        pixels_to_send.push_back('{8'hFF, 8'h00, 8'hFF});
        wait_idle();

        // side above max, second axis mirrored below zero, unmapped register
        apply_setting(4095, 0, 127, 1, 1);
        write_reg(REG_UNUSED, '1);
        pixels_to_send.push_back('{8'd9, 8'd9, 8'd9});
        pixels_to_send.push_back('{8'd0, 8'd0, 8'd0});
        pixels_to_send.push_back('{8'd250, 8'd251, 8'd252});
        wait_idle();

        // random settings and pixels under three pressure profiles
        remaining = RANDOM_PIXELS;
        while (remaining > 0) begin
            sent = RANDOM_PIXELS - remaining;
            if (sent < RANDOM_PIXELS / 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 76;
            end else if (sent < 2 * RANDOM_PIXELS / 3) begin
                send_idle_pct = 76;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0:       side = 0;
                1:       side = MAX_SIDE;
                2:       side = 127;
                3:       side = $urandom_range(127);
                default: side = $urandom_range(1, 5);
            endcase
            scale = ($urandom_range(99) < 60) ? $urandom_range(1, 3) : $urandom_range(15);
            apply_setting(random_origin(), random_origin(), side, scale, $urandom_range(3));
            n = $urandom_range(4, 18);
            if (n > remaining) n = remaining;
            repeat (n) pixels_to_send.push_back(random_pixel());
            remaining -= n;
            wait_idle();
        end

        $display("pixels sent: %0d opaque, %0d transparent; framebuffer writes checked: %0d",
                 n_opaque, n_clear, n_writes);
        $display("register settings applied: %0d, across three stall and gap profiles",
                 n_settings);
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
